### hdl/ptq_pkg.sv
// Shared types and constants for the priority task queue.
`timescale 1ns / 1ps

package ptq_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int ID_W  = 16;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [4:0]       t_cnt_out;
    typedef logic [ID_W-1:0]  t_id;

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_DEL    = 2'd1,
        REQ_DELALL = 2'd2,
        REQ_TICK   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_IDLE      = 2'd3
    } t_stat;

    typedef struct packed {
        t_id ctx_id;
        t_id task_num;
        t_id prio;
    } t_entry;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_TICK_IDLE,
        OP_FILT_INIT,
        OP_FILT_STEP,
        OP_FULL,
        OP_INS_INIT,
        OP_INS_STEP
    } t_op;

    typedef struct packed {
        t_op  op;
        logic emit;
    } t_cmd;

    typedef struct packed {
        t_req req;
        logic timer_on;
        logic cnt_zero;
        logic cnt_full;
        logic walk_done;
        logic ins_done;
        logic out_free;
    } t_sts;

endpackage

### hdl/ptq_ctrl.sv
// Request sequencer for the priority task queue.
`timescale 1ns / 1ps

module ptq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  ptq_pkg::t_sts i_sts,
    output ptq_pkg::t_cmd o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECIDE = 6'b000010,
        S_FILT   = 6'b000100,
        S_CHECK  = 6'b001000,
        S_INS    = 6'b010000,
        S_OUT    = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state    = r_state;
        o_cmd.op   = ptq_pkg::OP_NONE;
        o_cmd.emit = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = ptq_pkg::OP_LOAD;
                    n_state  = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.req == ptq_pkg::REQ_TICK && (!i_sts.timer_on || i_sts.cnt_zero)) begin
                    o_cmd.op = ptq_pkg::OP_TICK_IDLE;
                    n_state  = S_OUT;
                end else begin
                    o_cmd.op = ptq_pkg::OP_FILT_INIT;
                    n_state  = S_FILT;
                end
            end
            S_FILT: begin
                o_cmd.op = ptq_pkg::OP_FILT_STEP;
                if (i_sts.walk_done) begin
                    n_state = (i_sts.req == ptq_pkg::REQ_ADD) ? S_CHECK : S_OUT;
                end
            end
            S_CHECK: begin
                if (i_sts.cnt_full) begin
                    o_cmd.op = ptq_pkg::OP_FULL;
                    n_state  = S_OUT;
                end else begin
                    o_cmd.op = ptq_pkg::OP_INS_INIT;
                    n_state  = S_INS;
                end
            end
            S_INS: begin
                if (i_sts.ins_done) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.op = ptq_pkg::OP_INS_STEP;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_accept_decides: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_DECIDE))
        else $error("accepted beat did not start a request");

    a_emit_only_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> (r_state == S_OUT && i_sts.out_free))
        else $error("result emitted outside the output state");

endmodule

### hdl/ptq_datapath.sv
// Table memory, walk pointers, queue state and result register.
`timescale 1ns / 1ps

module ptq_datapath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ptq_pkg::t_cmd i_cmd,
    output ptq_pkg::t_sts o_sts,
    input  logic [1:0]    i_req_type,
    input  logic [15:0]   i_context_id,
    input  logic [15:0]   i_task_id,
    input  logic [15:0]   i_priority_req,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic [1:0]    o_status,
    output logic          o_dispatch_valid,
    output logic [15:0]   o_dispatch_context,
    output logic [15:0]   o_dispatch_task,
    output logic [4:0]    o_entry_count,
    output logic          o_timer_running
);

    ptq_pkg::t_entry r_mem [ptq_pkg::DEPTH];

    ptq_pkg::t_req   r_req;
    ptq_pkg::t_id    r_ctx;
    ptq_pkg::t_id    r_task;
    ptq_pkg::t_id    r_prio;
    ptq_pkg::t_stat  r_status;
    logic            r_found;
    logic            r_dv;
    ptq_pkg::t_id    r_dctx;
    ptq_pkg::t_id    r_dtask;

    ptq_pkg::t_cnt   r_count;
    logic            r_timer;

    ptq_pkg::t_idx   r_rd;
    ptq_pkg::t_cnt   r_left;
    ptq_pkg::t_cnt   r_wr;
    logic            r_rd_vld;
    ptq_pkg::t_idx   r_rd_idx;
    ptq_pkg::t_entry r_rd_data;
    logic            r_ins_done;

    logic            r_out_valid;
    ptq_pkg::t_stat  r_o_status;
    logic            r_o_dv;
    ptq_pkg::t_id    r_o_dctx;
    ptq_pkg::t_id    r_o_dtask;
    ptq_pkg::t_cnt   r_o_count;
    logic            r_o_timer;

    logic            filt_step;
    logic            ins_step;
    logic            issue;
    logic            walk_done;
    logic            drop;
    logic            ins_fin;
    logic            we;
    ptq_pkg::t_idx   wa;
    ptq_pkg::t_entry wd;
    ptq_pkg::t_entry new_entry;

    assign filt_step = (i_cmd.op == ptq_pkg::OP_FILT_STEP);
    assign ins_step  = (i_cmd.op == ptq_pkg::OP_INS_STEP) && !r_ins_done;
    assign issue     = (filt_step || ins_step) && (r_left != '0);
    assign walk_done = (r_left == '0) && !r_rd_vld;
    assign new_entry = '{ctx_id: r_ctx, task_num: r_task, prio: r_prio};

    always_comb begin
        unique case (r_req)
            ptq_pkg::REQ_ADD,
            ptq_pkg::REQ_DEL:    drop = (r_rd_data.ctx_id == r_ctx) &&
                                        (r_rd_data.task_num == r_task) && !r_found;
            ptq_pkg::REQ_DELALL: drop = (r_rd_data.ctx_id == r_ctx);
            ptq_pkg::REQ_TICK:   drop = (r_rd_idx == '0);
            default:             drop = 1'b0;
        endcase
    end

    always_comb begin
        we      = 1'b0;
        wa      = '0;
        wd      = r_rd_data;
        ins_fin = 1'b0;
        if (filt_step && r_rd_vld && !drop) begin
            we = 1'b1;
            wa = r_wr[ptq_pkg::IDX_W-1:0];
        end else if (ins_step) begin
            if (r_rd_vld) begin
                we = 1'b1;
                wa = ptq_pkg::t_idx'(r_rd_idx + 1'b1);
                if (r_rd_data.prio <= r_prio) begin
                    wd      = new_entry;
                    ins_fin = 1'b1;
                end
            end else if (r_left == '0) begin
                we      = 1'b1;
                wa      = '0;
                wd      = new_entry;
                ins_fin = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_data <= r_mem[r_rd];
        end
        if (we) begin
            r_mem[wa] <= wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == ptq_pkg::OP_LOAD) begin
            r_req  <= ptq_pkg::t_req'(i_req_type);
            r_ctx  <= i_context_id;
            r_task <= i_task_id;
            r_prio <= i_priority_req;
        end
        if (issue) begin
            r_rd_idx <= r_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_timer    <= 1'b0;
            r_left     <= '0;
            r_rd_vld   <= 1'b0;
            r_ins_done <= 1'b0;
            r_found    <= 1'b0;
            r_dv       <= 1'b0;
            r_status   <= ptq_pkg::ST_OK;
        end else begin
            unique case (i_cmd.op)
                ptq_pkg::OP_LOAD: begin
                    r_status <= ptq_pkg::ST_OK;
                    r_found  <= 1'b0;
                    r_dv     <= 1'b0;
                    r_dctx   <= '0;
                    r_dtask  <= '0;
                end
                ptq_pkg::OP_TICK_IDLE: begin
                    r_status <= ptq_pkg::ST_IDLE;
                    r_timer  <= 1'b0;
                end
                ptq_pkg::OP_FILT_INIT: begin
                    r_rd     <= '0;
                    r_left   <= r_count;
                    r_wr     <= '0;
                    r_rd_vld <= 1'b0;
                end
                ptq_pkg::OP_FILT_STEP: begin
                    r_rd_vld <= issue;
                    if (issue) begin
                        r_rd   <= ptq_pkg::t_idx'(r_rd + 1'b1);
                        r_left <= ptq_pkg::t_cnt'(r_left - 1'b1);
                    end
                    if (r_rd_vld) begin
                        if (drop) begin
                            r_found <= 1'b1;
                            if (r_req == ptq_pkg::REQ_TICK) begin
                                r_dv    <= 1'b1;
                                r_dctx  <= r_rd_data.ctx_id;
                                r_dtask <= r_rd_data.task_num;
                            end
                        end else begin
                            r_wr <= ptq_pkg::t_cnt'(r_wr + 1'b1);
                        end
                    end
                    if (walk_done) begin
                        r_count <= r_wr;
                        if (r_req == ptq_pkg::REQ_DEL && !r_found) begin
                            r_status <= ptq_pkg::ST_NOT_FOUND;
                        end
                        if (r_req == ptq_pkg::REQ_TICK && r_wr == '0) begin
                            r_timer <= 1'b0;
                        end
                    end
                end
                ptq_pkg::OP_FULL: begin
                    r_status <= ptq_pkg::ST_FULL;
                end
                ptq_pkg::OP_INS_INIT: begin
                    r_rd       <= ptq_pkg::t_idx'(r_count - 1'b1);
                    r_left     <= r_count;
                    r_rd_vld   <= 1'b0;
                    r_ins_done <= 1'b0;
                    if (r_count == '0) begin
                        r_timer <= 1'b1;
                    end
                end
                ptq_pkg::OP_INS_STEP: begin
                    if (ins_step) begin
                        r_rd_vld <= issue;
                        if (issue) begin
                            r_rd   <= ptq_pkg::t_idx'(r_rd - 1'b1);
                            r_left <= ptq_pkg::t_cnt'(r_left - 1'b1);
                        end
                        if (ins_fin) begin
                            r_ins_done <= 1'b1;
                            r_count    <= ptq_pkg::t_cnt'(r_count + 1'b1);
                        end
                    end
                end
                ptq_pkg::OP_NONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_status <= r_status;
            r_o_dv     <= r_dv;
            r_o_dctx   <= r_dctx;
            r_o_dtask  <= r_dtask;
            r_o_count  <= r_count;
            r_o_timer  <= r_timer;
        end
    end

    assign o_sts.req       = r_req;
    assign o_sts.timer_on  = r_timer;
    assign o_sts.cnt_zero  = (r_count == '0);
    assign o_sts.cnt_full  = (r_count == ptq_pkg::t_cnt'(ptq_pkg::DEPTH));
    assign o_sts.walk_done = walk_done;
    assign o_sts.ins_done  = r_ins_done;
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_o_status;
    assign o_dispatch_valid   = r_o_dv;
    assign o_dispatch_context = r_o_dctx;
    assign o_dispatch_task    = r_o_dtask;
    assign o_entry_count      = ptq_pkg::t_cnt_out'(r_o_count);
    assign o_timer_running    = r_o_timer;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ptq_pkg::t_cnt'(ptq_pkg::DEPTH))
        else $error("pending count exceeds table depth");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || !i_out_stall))
        else $error("result register overwritten while stalled");

    a_dispatch_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_dv) |-> (r_o_status == ptq_pkg::ST_OK))
        else $error("dispatched task reported with error status");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ins_step && ins_fin) |=> (r_count == ptq_pkg::t_cnt'($past(r_count) + 1'b1)))
        else $error("insertion did not grow the table by one");

endmodule

### hdl/priority_task_queue_unit.sv
// Top level of the priority task queue: sequencer plus table datapath.
// An add walks the entry table twice (once to filter, once to insert; once if it finds the
// table full), a delete, delete-all or dispatching tick once, and a tick that finds the timer
// stopped or the table empty not at all. The input stays stalled until the result is emitted.
// Reset is synchronous: the table is emptied and the timer stopped; entries are not cleared.
`timescale 1ns / 1ps

module priority_task_queue_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [15:0] i_context_id,
    input  logic [15:0] i_task_id,
    input  logic [15:0] i_priority_req,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic        o_dispatch_valid,
    output logic [15:0] o_dispatch_context,
    output logic [15:0] o_dispatch_task,
    output logic [4:0]  o_entry_count,
    output logic        o_timer_running
);

    ptq_pkg::t_cmd cmd;
    ptq_pkg::t_sts sts;

    ptq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ptq_datapath u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_req_type         (i_req_type),
        .i_context_id       (i_context_id),
        .i_task_id          (i_task_id),
        .i_priority_req     (i_priority_req),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_status           (o_status),
        .o_dispatch_valid   (o_dispatch_valid),
        .o_dispatch_context (o_dispatch_context),
        .o_dispatch_task    (o_dispatch_task),
        .o_entry_count      (o_entry_count),
        .o_timer_running    (o_timer_running)
    );

endmodule
